// ===== hdl/partial_update_region_adjust_defines.svh =====
// Assertion helpers for the checked modules.
// Each use names clk_i and rst_ni of the module that holds it.
`ifndef PARTIAL_UPDATE_REGION_ADJUST_DEFINES_SVH
`define PARTIAL_UPDATE_REGION_ADJUST_DEFINES_SVH

// Plain property, checked at every rising edge outside reset
`define PURA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define PURA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pura_pkg.sv =====
`default_nettype none

package pura_pkg;

  // Field widths
  localparam int CoordW    = 13;
  localparam int ReqWideW  = 14;
  localparam int SliceW    = 12;
  localparam int SvsW      = 17;
  localparam int FpsW      = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 17;

  // Stream widths
  localparam int InTdataW  = 56;
  localparam int OutTdataW = 40;
  localparam int OutTuserW = 3;

  // Tearing limit arithmetic
  localparam int NsPerSec  = 1000000000;
  localparam int NsPerUs   = 1000;
  localparam int MarginPct = 30;
  localparam int PctBase   = 100;
  localparam int LineScale = PctBase + MarginPct;
  localparam int DivW      = 30;
  localparam int DivCntW   = $clog2(DivW);
  localparam int VsNsW     = 27;

  // Line count as v_active * LineScale / PctBase through a reciprocal multiply;
  // exact for every scaled height that a 13-bit v_active can give (up to 1064830)
  localparam int ScaledW   = 21;
  localparam int RecipSh   = 27;
  localparam int RecipW    = 21;
  localparam int ProdW     = ScaledW + RecipW;
  localparam int LinesW    = 14;
  localparam logic [RecipW-1:0] RecipPct =
    RecipW'(((64'd1 << RecipSh) + 64'(PctBase) - 64'd1) / 64'(PctBase));

  localparam logic [CoordW-1:0] DefaultBlock = CoordW'(2);
  localparam logic [CoordW-1:0] CoordMax     = '1;

  // Queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Register reset values
  localparam logic [CoordW-1:0] HActiveRst = CoordW'(1080);
  localparam logic [CoordW-1:0] VActiveRst = CoordW'(2400);
  localparam logic              DscRst     = 1'b0;
  localparam logic [SliceW-1:0] SliceRst   = SliceW'(8);
  localparam logic [SvsW-1:0]   SvsRst     = '0;
  localparam logic [FpsW-1:0]   FpsRst     = FpsW'(60);

  typedef enum logic [CfgIdxW-1:0] {
    REG_H_ACTIVE   = 3'd0,
    REG_V_ACTIVE   = 3'd1,
    REG_DSC_ENABLE = 3'd2,
    REG_SLICE      = 3'd3,
    REG_SVSYNC     = 3'd4,
    REG_FRAME_RATE = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RSN_OK      = 2'd0,
    RSN_EMPTY   = 2'd1,
    RSN_OUTSIDE = 2'd2,
    RSN_TEAR    = 2'd3
  } reason_e;

  typedef enum logic [2:0] {
    CS_START,
    CS_FRAME,
    CS_LINE_NS,
    CS_VS_LINES,
    CS_IDLE
  } cfg_state_e;

  // Configuration and derived values handed to the datapath
  typedef struct packed {
    logic [CoordW-1:0] h_active;
    logic [CoordW-1:0] v_active;
    logic [CoordW-1:0] blk;
    logic [CoordW-1:0] tear_lim;
    logic              svs_on;
    logic              ready;
  } cfg_t;

  // Classified request waiting for the back part
  typedef struct packed {
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] y2;
    reason_e           cls;
  } qent_t;

endpackage

`default_nettype wire

// ===== hdl/pura_cfg.sv =====
`default_nettype none

module pura_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pura_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pura_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output pura_pkg::cfg_t                 cfg_o
);
  import pura_pkg::*;

  logic [CoordW-1:0] h_q, v_q;
  logic              dsc_q;
  logic [SliceW-1:0] slice_q;
  logic [SvsW-1:0]   svs_q;
  logic [FpsW-1:0]   fps_q;

  cfg_state_e        state_q, state_d;
  logic [CoordW-1:0] lim_q, lim_d;

  logic [DivW-1:0]    div_rem_q, div_quo_q, div_dvs_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               div_busy_q;
  logic [DivW:0]      div_sh;
  logic               div_ge;
  logic [DivW-1:0]    div_rem_nx;

  logic              div_ld;
  logic [DivW-1:0]   ld_dividend, ld_divisor;
  logic [CoordW-1:0] blk;
  logic [FpsW-1:0]   fps;
  logic [VsNsW-1:0]  vs_ns;
  logic [DivW-1:0]   frame_dividend;

  logic [ScaledW-1:0] scaled_q;
  logic [ProdW-1:0]   lines_prod;
  logic [LinesW-1:0]  lines_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= HActiveRst;
      v_q     <= VActiveRst;
      dsc_q   <= DscRst;
      slice_q <= SliceRst;
      svs_q   <= SvsRst;
      fps_q   <= FpsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_H_ACTIVE:   h_q     <= cfg_wdata_i[CoordW-1:0];
        REG_V_ACTIVE:   v_q     <= cfg_wdata_i[CoordW-1:0];
        REG_DSC_ENABLE: dsc_q   <= cfg_wdata_i[0];
        REG_SLICE:      slice_q <= cfg_wdata_i[SliceW-1:0];
        REG_SVSYNC:     svs_q   <= cfg_wdata_i[SvsW-1:0];
        REG_FRAME_RATE: fps_q   <= cfg_wdata_i[FpsW-1:0];
        default: ;
      endcase
    end
  end

  // Row block: slice height with DSC on and a nonzero slice, doubled when odd, else two lines
  always_comb begin
    blk = DefaultBlock;
    if (dsc_q && slice_q != '0) begin
      blk = slice_q[0] ? {slice_q, 1'b0} : {1'b0, slice_q};
    end
  end

  // Divider operands
  assign fps            = (fps_q == '0) ? FpsW'(1) : fps_q;
  assign vs_ns          = VsNsW'(svs_q) * VsNsW'(NsPerUs);
  assign frame_dividend = DivW'(NsPerSec) + DivW'(fps) - DivW'(1);

  // Line count, registered in scaled_q and then lines_q after a height write, settles long before use
  assign lines_prod = ProdW'(scaled_q) * ProdW'(RecipPct);

  always_ff @(posedge clk_i) begin
    scaled_q <= ScaledW'(v_q) * ScaledW'(LineScale);
    lines_q  <= lines_prod[RecipSh +: LinesW];
  end

  // Shared restoring divider, one quotient bit a cycle
  assign div_sh     = {div_rem_q, div_quo_q[DivW-1]};
  assign div_ge     = div_sh >= {1'b0, div_dvs_q};
  assign div_rem_nx = div_ge ? DivW'(div_sh - {1'b0, div_dvs_q}) : div_sh[DivW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_ld) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
      if (div_cnt_q == DivCntW'(DivW - 1)) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ld) begin
      div_rem_q <= '0;
      div_quo_q <= ld_dividend;
      div_dvs_q <= ld_divisor;
    end else if (div_busy_q) begin
      div_rem_q <= div_rem_nx;
      div_quo_q <= {div_quo_q[DivW-2:0], div_ge};
    end
  end

  // Tearing limit sequencer, restarted by every register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_START;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
  end

  always_comb begin
    state_d     = state_q;
    lim_d       = lim_q;
    div_ld      = 1'b0;
    ld_dividend = '0;
    ld_divisor  = '0;
    case (state_q)
      CS_START: begin
        div_ld      = 1'b1;
        ld_dividend = frame_dividend;
        ld_divisor  = DivW'(fps);
        state_d     = CS_FRAME;
      end
      CS_FRAME: begin
        if (!div_busy_q) begin
          // Vsync time over one frame or no lines at all: limit is zero
          if (DivW'(vs_ns) > div_quo_q || lines_q == '0) begin
            lim_d   = '0;
            state_d = CS_IDLE;
          end else begin
            div_ld      = 1'b1;
            ld_dividend = div_quo_q;
            ld_divisor  = DivW'(lines_q);
            state_d     = CS_LINE_NS;
          end
        end
      end
      CS_LINE_NS: begin
        if (!div_busy_q) begin
          if (div_quo_q == '0) begin
            lim_d   = '0;
            state_d = CS_IDLE;
          end else begin
            div_ld      = 1'b1;
            ld_dividend = DivW'(vs_ns);
            ld_divisor  = div_quo_q;
            state_d     = CS_VS_LINES;
          end
        end
      end
      CS_VS_LINES: begin
        if (!div_busy_q) begin
          // Saturate at zero when the vsync lines cover the display
          if (div_quo_q >= DivW'(v_q)) begin
            lim_d = '0;
          end else begin
            lim_d = v_q - div_quo_q[CoordW-1:0];
          end
          state_d = CS_IDLE;
        end
      end
      CS_IDLE: ;
      default: state_d = CS_START;
    endcase
    if (cfg_we_i) begin
      state_d = CS_START;
    end
  end

  assign cfg_o.h_active = h_q;
  assign cfg_o.v_active = v_q;
  assign cfg_o.blk      = blk;
  assign cfg_o.tear_lim = lim_q;
  assign cfg_o.svs_on   = svs_q != '0;
  assign cfg_o.ready    = state_q == CS_IDLE;

endmodule

`default_nettype wire

// ===== hdl/pura_front.sv =====
`default_nettype none

module pura_front (
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [pura_pkg::InTdataW-1:0]  s_tdata_i,
  input  pura_pkg::cfg_t                 cfg_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output pura_pkg::qent_t                q_ent_o
);
  import pura_pkg::*;

  logic [CoordW-1:0]   x1, y1;
  logic [ReqWideW-1:0] x2, y2;

  // Unpack the request
  assign x1 = s_tdata_i[CoordW-1:0];
  assign y1 = s_tdata_i[2*CoordW-1:CoordW];
  assign x2 = s_tdata_i[2*CoordW+ReqWideW-1:2*CoordW];
  assign y2 = s_tdata_i[2*CoordW+2*ReqWideW-1:2*CoordW+ReqWideW];

  // Hold off while the limit is recomputed or the queue is full
  assign s_tready_o = cfg_i.ready && !q_full_i;
  assign q_push_o   = s_tvalid_i && s_tready_o;

  // Classify: empty request first, then past the display edge
  always_comb begin
    q_ent_o.y1  = y1;
    q_ent_o.y2  = y2[CoordW-1:0];
    q_ent_o.cls = RSN_OK;
    if (x1 == '0 && y1 == '0 && x2 == '0 && y2 == '0) begin
      q_ent_o.cls = RSN_EMPTY;
    end else if (x2 > {1'b0, cfg_i.h_active} || y2 > {1'b0, cfg_i.v_active}) begin
      q_ent_o.cls = RSN_OUTSIDE;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pura_queue.sv =====
`default_nettype none

module pura_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pura_pkg::qent_t  ent_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             vld_o,
  output pura_pkg::qent_t  ent_o
);
  import pura_pkg::*;

  qent_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ent_i;
    end
  end

  assign full_o = cnt_q == QCntW'(QueueDepth);
  assign vld_o  = cnt_q != '0;
  assign ent_o  = mem_q[rd_q];

endmodule

`default_nettype wire

// ===== hdl/pura_back.sv =====
`default_nettype none
`include "partial_update_region_adjust_defines.svh"

module pura_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_vld_i,
  input  pura_pkg::qent_t                 q_ent_i,
  output logic                            q_pop_o,
  input  pura_pkg::cfg_t                  cfg_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [pura_pkg::OutTdataW-1:0]  m_tdata_o,
  output logic [pura_pkg::OutTuserW-1:0]  m_tuser_o
);
  import pura_pkg::*;

  localparam int NumStg = CoordW;
  localparam int Last   = NumStg - 1;

  // One remainder bit step against the row block
  function automatic logic [CoordW-1:0] rem_step(input logic [CoordW-1:0] r,
                                                 input logic b,
                                                 input logic [CoordW-1:0] d);
    logic [CoordW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[CoordW-1:0];
  endfunction

  logic              advance;
  logic              stg_vld_q [NumStg];
  qent_t             stg_ent_q [NumStg];
  logic [CoordW-1:0] stg_r1_q  [NumStg];
  logic [CoordW-1:0] stg_r2_q  [NumStg];

  logic              out_vld_q, out_vld_d;
  logic [CoordW-1:0] out_y1_q, out_x2_q, out_y2_q;
  logic              out_full_q;
  reason_e           out_rsn_q;

  logic [CoordW-1:0] fy1, fy2;
  logic [CoordW:0]   up;
  logic              tear;
  reason_e           rsn;

  // Whole pipeline moves when the output register is free or drained
  assign advance = !out_vld_q || m_tready_i;
  assign q_pop_o = advance && q_vld_i;

  // Remainder pipeline: stage s resolves bit (msb - s) of y1 and y2
  for (genvar s = 0; s < NumStg; s++) begin : g_stg
    logic              in_vld;
    qent_t             in_ent;
    logic [CoordW-1:0] in_r1, in_r2;

    if (s == 0) begin : g_first
      assign in_vld = q_vld_i;
      assign in_ent = q_ent_i;
      assign in_r1  = '0;
      assign in_r2  = '0;
    end else begin : g_next
      assign in_vld = stg_vld_q[s-1];
      assign in_ent = stg_ent_q[s-1];
      assign in_r1  = stg_r1_q[s-1];
      assign in_r2  = stg_r2_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_vld_q[s] <= 1'b0;
      end else if (advance) begin
        stg_vld_q[s] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        stg_ent_q[s] <= in_ent;
        stg_r1_q[s]  <= rem_step(in_r1, in_ent.y1[CoordW-1-s], cfg_i.blk);
        stg_r2_q[s]  <= rem_step(in_r2, in_ent.y2[CoordW-1-s], cfg_i.blk);
      end
    end
  end

  // Round y1 down and y2 up, apply the tearing check, and give the whole display for any class but OK
  always_comb begin
    fy1  = stg_ent_q[Last].y1 - stg_r1_q[Last];
    up   = {1'b0, stg_ent_q[Last].y2} - {1'b0, stg_r2_q[Last]}
         + ((stg_r2_q[Last] != '0) ? {1'b0, cfg_i.blk} : '0);
    fy2  = up[CoordW] ? CoordMax : up[CoordW-1:0];
    tear = cfg_i.svs_on && (fy1 >= cfg_i.tear_lim);
    rsn  = stg_ent_q[Last].cls;
    if (stg_ent_q[Last].cls == RSN_OK && tear) begin
      rsn = RSN_TEAR;
    end
    if (rsn != RSN_OK) begin
      fy1 = '0;
      fy2 = cfg_i.v_active;
    end
  end

  // Output register
  assign out_vld_d = advance ? stg_vld_q[Last] : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_y1_q   <= fy1;
      out_x2_q   <= cfg_i.h_active;
      out_y2_q   <= fy2;
      out_full_q <= rsn != RSN_OK;
      out_rsn_q  <= rsn;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {1'b0, out_y2_q, out_x2_q, out_y1_q};
  assign m_tuser_o  = {out_rsn_q, out_full_q};

  `PURA_ASSERT_NEXT(a_stall_hold, out_vld_q && !m_tready_i, out_vld_q && $stable(stg_vld_q[Last]), "pipeline moved while the output was stalled")
  `PURA_ASSERT(a_tear_needs_svs, (out_vld_q && out_rsn_q == RSN_TEAR) |-> cfg_i.svs_on, "tearing fallback without a vsync time")
  `PURA_ASSERT(a_full_region, (out_vld_q && out_full_q) |-> (out_y1_q == '0 && out_y2_q == cfg_i.v_active), "full screen result is not the whole display")

endmodule

`default_nettype wire

// ===== hdl/partial_update_region_adjust.sv =====
// A request taken with an empty queue goes through the queue, the remainder
// stages and the output register. Throughput: one request per cycle while
// both ready signals are high; a 4-entry queue and the output register
// decouple the request side from the result side. Reset (rst_ni low,
// asynchronous) loads the register defaults; then a shared 30-bit divider
// computes the tearing limit with s_axis_tready low; every write restarts it.
`default_nettype none

module partial_update_region_adjust (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // req_x1[12:0], req_y1[25:13], req_x2[39:26], req_y2[53:40], zero [55:54]
  input  logic [pura_pkg::InTdataW-1:0]   s_axis_tdata,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_y1[12:0], out_x2[25:13], out_y2[38:26], zero [39]
  output logic [pura_pkg::OutTdataW-1:0]  m_axis_tdata,
  // used_full[0], reason[2:1]
  output logic [pura_pkg::OutTuserW-1:0]  m_axis_tuser,
  // Register write port
  input  logic                            cfg_we_i,
  input  logic [pura_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pura_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import pura_pkg::*;

  cfg_t  cfg;
  qent_t push_ent, head_ent;
  logic  q_push, q_pop, q_full, q_vld;

  // Registers and tearing limit
  pura_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Accept and classify requests
  pura_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_ent_o    (push_ent)
  );

  // Queue between classification and rounding
  pura_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .ent_i  (push_ent),
    .pop_i  (q_pop),
    .full_o (q_full),
    .vld_o  (q_vld),
    .ent_o  (head_ent)
  );

  // Round to the row block and build the result
  pura_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_vld_i    (q_vld),
    .q_ent_i    (head_ent),
    .q_pop_o    (q_pop),
    .cfg_i      (cfg),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
